[hw/rtl/pca_pkg.sv]
// ============================================================================
// pca_pkg: shared widths and codes for the polygon centroid accumulator
// Holds the fixed-point widths of the accumulators and the divider, and the
// status codes that go out with each centroid word.
// ============================================================================
package pca_pkg;

    // Coordinates are unsigned Q0.16 in the unit box.
    localparam int COORD_BITS = 16;
    // Sum of two coordinates.
    localparam int SUM_W = COORD_BITS + 1;
    // Signed multiplier operands and product.
    localparam int OPA_W = SUM_W + 1;
    localparam int DET_W = 2 * COORD_BITS + 2;
    localparam int PROD_W = OPA_W + DET_W;
    // Accumulator widths.
    localparam int AREA_W = 39;
    localparam int MOM_W = 56;
    // Three times the area magnitude, and the divider datapath.
    localparam int D3_W = AREA_W + 2;
    localparam int DIV_W = MOM_W + 2;
    localparam int STEP_W = $clog2(COORD_BITS + 1);
    // Default edge limit per polygon.
    localparam int MAX_EDGES_DEF = 64;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO_AREA = 2'd1,
        STAT_CLAMPED   = 2'd2,
        STAT_TOO_MANY  = 2'd3
    } status_t;

endpackage

[hw/rtl/polygon_centroid_accumulator_core.sv]
// ============================================================================
// polygon_centroid_accumulator_core: shoelace centroid of a polygon
// Accumulates the doubled signed area and the first moments of a polygon
// given edge by edge, then divides the moments by three times the area.
// ============================================================================
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+------------------------------------
//  in      | to block  | in_valid/in_stall  | start_x, start_y, end_x, end_y,
//          |           |                    | last_edge
//  out     | from block| out_valid/out_stall| centroid_x, centroid_y, status
//
//  An edge word is taken in the accept cycle, then passes six steps of the one
//  shared 18 x 34 signed multiplier (two products for the cross product, two
//  for the moments, each followed by an accumulate).
//  After the last edge come S_P0 for status and area magnitude, then per
//  axis the setup states S_P1 and S_P2, 17 restoring divider steps on the
//  shared subtractor and the rounding/clamping state S_FIN, then S_EMIT to
//  hand the word to the output register.
//  in_stall is low only while the sequencer is idle. A finished centroid
//  waits in the output register, so the next polygon may start meanwhile; a
//  new result waits for that register to empty before the sums are cleared.
//  rst_n is asynchronous and active low; it clears the sums, the edge count
//  and the sequencer.
//
module polygon_centroid_accumulator_core
    import pca_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic                  last_edge,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] centroid_x,
    output logic [COORD_BITS-1:0] centroid_y,
    output logic [1:0]            status
);

    // The edge counter has to hold the limit plus one, which marks overflow.
    localparam int ECNT_W = $clog2(MAX_EDGES + 2);
    localparam logic [ECNT_W-1:0] ECNT_MAX = ECNT_W'(MAX_EDGES);
    localparam logic [ECNT_W-1:0] ECNT_OVER = ECNT_W'(MAX_EDGES + 1);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(COORD_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_P0,
        S_P1,
        S_P2,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [COORD_BITS-1:0]      x1_reg, x1_next;
    logic [COORD_BITS-1:0]      y1_reg, y1_next;
    logic [COORD_BITS-1:0]      x2_reg, x2_next;
    logic [COORD_BITS-1:0]      y2_reg, y2_next;
    logic                       last_reg, last_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [DET_W-1:0]    det_reg, det_next;
    logic [AREA_W-1:0]          area_sum_reg, area_sum_next;
    logic [MOM_W-1:0]           mom_x_sum_reg, mom_x_sum_next;
    logic [MOM_W-1:0]           mom_y_sum_reg, mom_y_sum_next;
    logic [ECNT_W-1:0]          edge_count_reg, edge_count_next;
    logic [AREA_W-1:0]          amag_reg, amag_next;
    logic                       aneg_reg, aneg_next;
    logic [MOM_W-1:0]           mmag_reg, mmag_next;
    logic                       mneg_reg, mneg_next;
    logic [D3_W-1:0]            d3_reg, d3_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W-1:0]           dsh_reg, dsh_next;
    logic [COORD_BITS:0]        q_reg, q_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       axis_reg, axis_next;
    logic                       clamp_reg, clamp_next;
    logic [COORD_BITS-1:0]      cx_reg, cx_next;
    logic [COORD_BITS-1:0]      cy_reg, cy_next;
    status_t                    st_reg, st_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]      centroid_x_reg, centroid_x_next;
    logic [COORD_BITS-1:0]      centroid_y_reg, centroid_y_next;
    status_t                    status_reg, status_next;

    // Shared multiplier.
    logic signed [OPA_W-1:0]    mul_a;
    logic signed [DET_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_out;
    logic [SUM_W-1:0]           sum_x;
    logic [SUM_W-1:0]           sum_y;

    // Shared subtractor of the restoring divider.
    logic [DIV_W:0]             div_diff;
    logic                       div_ge;

    // Axis result after rounding and clamping.
    logic [MOM_W-1:0]           mom_sel;
    logic [COORD_BITS-1:0]      axis_val;
    logic                       axis_clamp;
    logic                       in_accept;
    logic                       out_load;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;
    assign status     = status_reg;

    assign sum_x = SUM_W'(x1_reg) + SUM_W'(x2_reg);
    assign sum_y = SUM_W'(y1_reg) + SUM_W'(y2_reg);

    // Operand selection: the cross product terms first, then the moments.
    always_comb
    begin
        case (state_reg)
            S_M0:
            begin
                mul_a = signed'(OPA_W'(x1_reg));
                mul_b = signed'(DET_W'(y2_reg));
            end
            S_M1:
            begin
                mul_a = signed'(OPA_W'(x2_reg));
                mul_b = signed'(DET_W'(y1_reg));
            end
            S_M3:
            begin
                mul_a = signed'(OPA_W'(sum_x));
                mul_b = det_reg;
            end
            S_M4:
            begin
                mul_a = signed'(OPA_W'(sum_y));
                mul_b = det_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    assign div_diff = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign div_ge   = !div_diff[DIV_W];

    assign mom_sel = axis_reg ? mom_y_sum_reg : mom_x_sum_reg;

    // Bit COORD_BITS of the quotient set means the quotient does not fit.
    // A result of opposite sign to the area lies outside the box and clamps
    // to zero, unless it rounds to zero anyway.
    always_comb
    begin
        axis_val   = '0;
        axis_clamp = 1'b0;
        if (q_reg[COORD_BITS])
        begin
            axis_clamp = 1'b1;
            axis_val   = (mneg_reg != aneg_reg) ? '0 : '1;
        end
        else if (q_reg[COORD_BITS-1:0] == '0)
        begin
            axis_val = '0;
        end
        else if (mneg_reg != aneg_reg)
        begin
            axis_clamp = 1'b1;
            axis_val   = '0;
        end
        else
        begin
            axis_val = q_reg[COORD_BITS-1:0];
        end
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        det_next        = det_reg;
        area_sum_next   = area_sum_reg;
        mom_x_sum_next  = mom_x_sum_reg;
        mom_y_sum_next  = mom_y_sum_reg;
        edge_count_next = edge_count_reg;
        amag_next       = amag_reg;
        aneg_next       = aneg_reg;
        mmag_next       = mmag_reg;
        mneg_next       = mneg_reg;
        d3_next         = d3_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        step_next       = step_reg;
        axis_next       = axis_reg;
        clamp_next      = clamp_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        st_next         = st_reg;
        centroid_x_next = centroid_x_reg;
        centroid_y_next = centroid_y_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    x1_next   = start_x;
                    y1_next   = start_y;
                    x2_next   = end_x;
                    y2_next   = end_y;
                    last_next = last_edge;
                    if (edge_count_reg < ECNT_MAX)
                    begin
                        state_next = S_M0;
                    end
                    else
                    begin
                        // Edges past the limit are dropped and only flagged.
                        edge_count_next = ECNT_OVER;
                        state_next      = last_edge ? S_P0 : S_IDLE;
                    end
                end
            end
            S_M0:
            begin
                prod_next  = mul_out;
                state_next = S_M1;
            end
            S_M1:
            begin
                det_next   = prod_reg[DET_W-1:0];
                prod_next  = mul_out;
                state_next = S_M2;
            end
            S_M2:
            begin
                det_next   = det_reg - prod_reg[DET_W-1:0];
                state_next = S_M3;
            end
            S_M3:
            begin
                prod_next     = mul_out;
                area_sum_next = area_sum_reg + AREA_W'(det_reg);
                state_next    = S_M4;
            end
            S_M4:
            begin
                mom_x_sum_next = mom_x_sum_reg + MOM_W'(prod_reg);
                prod_next      = mul_out;
                state_next     = S_M5;
            end
            S_M5:
            begin
                mom_y_sum_next  = mom_y_sum_reg + MOM_W'(prod_reg);
                edge_count_next = edge_count_reg + ECNT_W'(1);
                state_next      = last_reg ? S_P0 : S_IDLE;
            end
            S_P0:
            begin
                cx_next    = '0;
                cy_next    = '0;
                axis_next  = 1'b0;
                clamp_next = 1'b0;
                if (edge_count_reg > ECNT_MAX)
                begin
                    st_next    = STAT_TOO_MANY;
                    state_next = S_EMIT;
                end
                else if (area_sum_reg == '0)
                begin
                    st_next    = STAT_ZERO_AREA;
                    state_next = S_EMIT;
                end
                else
                begin
                    aneg_next  = area_sum_reg[AREA_W-1];
                    amag_next  = area_sum_reg[AREA_W-1] ?
                                 (~area_sum_reg + AREA_W'(1)) : area_sum_reg;
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                mneg_next  = mom_sel[MOM_W-1];
                mmag_next  = mom_sel[MOM_W-1] ? (~mom_sel + MOM_W'(1)) : mom_sel;
                d3_next    = D3_W'({amag_reg, 1'b0}) + D3_W'(amag_reg);
                state_next = S_P2;
            end
            S_P2:
            begin
                // Rounded quotient: (2*m + 3*a) / (6*a).
                rem_next   = DIV_W'({mmag_reg, 1'b0}) + DIV_W'(d3_reg);
                dsh_next   = DIV_W'({d3_reg, 1'b0}) << COORD_BITS;
                q_next     = '0;
                step_next  = STEP_FIRST;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = div_diff[DIV_W-1:0];
                end
                q_next   = {q_reg[COORD_BITS-1:0], div_ge};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_FIN:
            begin
                if (!axis_reg)
                begin
                    cx_next    = axis_val;
                    clamp_next = axis_clamp;
                    axis_next  = 1'b1;
                    state_next = S_P1;
                end
                else
                begin
                    cy_next    = axis_val;
                    st_next    = (clamp_reg || axis_clamp) ? STAT_CLAMPED : STAT_OK;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    centroid_x_next = cx_reg;
                    centroid_y_next = cy_reg;
                    status_next     = st_reg;
                    area_sum_next   = '0;
                    mom_x_sum_next  = '0;
                    mom_y_sum_next  = '0;
                    edge_count_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            area_sum_reg   <= '0;
            mom_x_sum_reg  <= '0;
            mom_y_sum_reg  <= '0;
            edge_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            centroid_x_reg <= '0;
            centroid_y_reg <= '0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            area_sum_reg   <= area_sum_next;
            mom_x_sum_reg  <= mom_x_sum_next;
            mom_y_sum_reg  <= mom_y_sum_next;
            edge_count_reg <= edge_count_next;
            out_valid_reg  <= out_valid_next;
            centroid_x_reg <= centroid_x_next;
            centroid_y_reg <= centroid_y_next;
            status_reg     <= status_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        x2_reg         <= x2_next;
        y2_reg         <= y2_next;
        last_reg       <= last_next;
        prod_reg       <= prod_next;
        det_reg        <= det_next;
        amag_reg       <= amag_next;
        aneg_reg       <= aneg_next;
        mmag_reg       <= mmag_next;
        mneg_reg       <= mneg_next;
        d3_reg         <= d3_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        step_reg       <= step_next;
        axis_reg       <= axis_next;
        clamp_reg      <= clamp_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        st_reg         <= st_next;
    end

    // A new centroid word appears only from the hand-off state.
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("centroid word appeared outside the hand-off state");

    // Handing off a result leaves the sums and the edge count cleared.
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (area_sum_reg == '0 && mom_x_sum_reg == '0 &&
                      mom_y_sum_reg == '0 && edge_count_reg == '0))
        else $error("sums not cleared after a result");

    // The edge count never passes the overflow mark.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ECNT_OVER)
        else $error("edge count beyond the overflow mark");

    // Zero-area and too-many-edges results carry a zero centroid.
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STAT_ZERO_AREA ||
                           status_reg == STAT_TOO_MANY))
        |-> (centroid_x_reg == '0 && centroid_y_reg == '0))
        else $error("special-case status with a nonzero centroid");

endmodule
